// ===== design/rtbc_pkg.sv =====
// Shared constants, types and helpers for the raster tile binarize and classify core.
package rtbc_pkg;

  // Tile geometry; the tile edge is a multiple of eight pixels.
  localparam int unsigned TILE_SIZE        = 64;
  localparam int unsigned MAX_TILES_ACROSS = 64;
  localparam int unsigned TILE_LOG2        = $clog2(TILE_SIZE);
  localparam int unsigned COL_W            = 6;
  localparam int unsigned LINE_W           = 6;
  localparam int unsigned GRP_W            = 3;
  localparam int unsigned BAND_W           = 6;
  localparam int unsigned PX_W             = TILE_LOG2 + COL_W;
  localparam int unsigned TA_W             = 7;
  localparam int unsigned GROUPS_PER_LINE  = TILE_SIZE / 8;

  // Per-column seen flags: bit 0 a clear pixel, bit 1 a set pixel.
  localparam logic [1:0] SEEN_CLEAR = 2'b01;
  localparam logic [1:0] SEEN_SET   = 2'b10;

  // Tile kind codes.
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_BLOCKED = 2'd1;
  localparam logic [1:0] KIND_MIXED   = 2'd2;

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] REG_INVERT_INPUT = 2'd1;
  localparam logic [1:0] REG_TILES_ACROSS = 2'd2;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic            pixel_mode;
    logic            invert_input;
    logic [TA_W-1:0] tiles_across;
  } cfg_t;

  // One packed group and its place in the tile grid.
  typedef struct packed {
    logic [7:0]        bits;
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] line;
    logic [GRP_W-1:0]  grp;
    logic [BAND_W-1:0] band;
    logic              done;
  } grp_t;

  // Reverse the bit order of a byte so the first pixel lands in bit 0.
  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

// ===== design/rtbc_pack.sv =====
// Pixel binarizer, group packer and raster position counters.
module rtbc_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  rtbc_pkg::cfg_t cfg,
  input  logic           acc,
  input  logic [7:0]     raw_byte,
  output logic           emit,
  output rtbc_pkg::grp_t grp_o
);
  import rtbc_pkg::*;

  logic [2:0]        cnt_r, cnt_nxt;
  logic [7:0]        part_r, part_nxt;
  logic [PX_W-1:0]   px_r, px_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;

  logic [7:0]        b;
  logic [7:0]        rb;
  logic [15:0]       merged;
  logic [7:0]        single;
  logic [7:0]        bits;
  logic [TA_W-1:0]   tcount;
  logic [PX_W:0]     px_sum;
  logic [PX_W:0]     row_end;
  logic [LINE_W:0]   line_sum;
  logic [BAND_W:0]   band_sum;

  // Clamp the tile count to its legal range.
  always_comb begin
    if (cfg.tiles_across == '0) begin
      tcount = TA_W'(1);
    end else if (cfg.tiles_across > TA_W'(MAX_TILES_ACROSS)) begin
      tcount = TA_W'(MAX_TILES_ACROSS);
    end else begin
      tcount = cfg.tiles_across;
    end
  end

  // Binarize the byte and merge its pixels into the partial group.
  always_comb begin
    b      = raw_byte ^ {8{cfg.invert_input}};
    rb     = rev8(b);
    merged = {8'd0, part_r} | ({8'd0, rb} << cnt_r);
    single = part_r | (8'(|b) << cnt_r);
    if (cfg.pixel_mode) begin
      emit     = 1'b1;
      bits     = merged[7:0];
      part_nxt = merged[15:8];
      cnt_nxt  = cnt_r;
    end else begin
      emit     = (cnt_r == 3'd7);
      bits     = single;
      part_nxt = emit ? 8'd0 : single;
      cnt_nxt  = cnt_r + 3'd1;
    end
  end

  // Current group position.
  always_comb begin
    grp_o.bits = bits;
    grp_o.col  = px_r[PX_W-1:TILE_LOG2];
    grp_o.line = line_r;
    grp_o.grp  = GRP_W'(px_r[TILE_LOG2-1:3]);
    grp_o.band = band_r;
    grp_o.done = (line_r == LINE_W'(TILE_SIZE - 1)) &&
                 (px_r[TILE_LOG2-1:3] == GRP_W'(GROUPS_PER_LINE - 1));
  end

  // Advance x, line and band after each emitted group.
  always_comb begin
    px_sum   = {1'b0, px_r} + (PX_W+1)'(8);
    row_end  = {tcount[TA_W-1:0], {TILE_LOG2{1'b0}}};
    line_sum = {1'b0, line_r} + (LINE_W+1)'(1);
    band_sum = {1'b0, band_r} + (BAND_W+1)'(1);
    px_nxt   = px_r;
    line_nxt = line_r;
    band_nxt = band_r;
    if (emit) begin
      if (px_sum >= row_end) begin
        px_nxt = '0;
        if (line_sum >= (LINE_W+1)'(TILE_SIZE)) begin
          line_nxt = '0;
          if (band_sum >= (BAND_W+1)'(tcount)) begin
            band_nxt = '0;
          end else begin
            band_nxt = band_sum[BAND_W-1:0];
          end
        end else begin
          line_nxt = line_sum[LINE_W-1:0];
        end
      end else begin
        px_nxt = px_sum[PX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      part_r <= '0;
      px_r   <= '0;
      line_r <= '0;
      band_r <= '0;
    end else if (acc) begin
      cnt_r  <= cnt_nxt;
      part_r <= part_nxt;
      px_r   <= px_nxt;
      line_r <= line_nxt;
      band_r <= band_nxt;
    end
  end

endmodule

// ===== design/rtbc_seen.sv =====
// Per-column seen-flag memory with read-modify-write and tile classification.
module rtbc_seen (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [rtbc_pkg::COL_W-1:0] rd_col,
  input  logic                       wr_en,
  input  rtbc_pkg::grp_t             grp_i,
  output logic [1:0]                 kind
);
  import rtbc_pkg::*;

  localparam int unsigned DEPTH = 1 << COL_W;

  logic [1:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [1:0]       rd_data_r;
  logic             rd_vld_r;
  logic             lw_vld_r;
  logic [COL_W-1:0] lw_col_r;
  logic [1:0]       lw_data_r;
  logic [1:0]       cur;
  logic [1:0]       f;
  logic [1:0]       wr_data;

  // Synchronous read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_col];
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[grp_i.col] <= wr_data;
    end
  end

  // Valid bits mark columns written since reset; the last write is kept for forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      lw_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_col];
      end
      if (wr_en) begin
        vld_r[grp_i.col] <= 1'b1;
        lw_vld_r         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_col_r  <= grp_i.col;
      lw_data_r <= wr_data;
    end
  end

  // Merge this group into the column flags and classify on the tile's last group.
  always_comb begin
    if (lw_vld_r && (lw_col_r == grp_i.col)) begin
      cur = lw_data_r;
    end else if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur = 2'b00;
    end
    f = cur;
    if (grp_i.bits != 8'h00) f = f | SEEN_SET;
    if (grp_i.bits != 8'hFF) f = f | SEEN_CLEAR;
    kind    = KIND_CLEAR;
    wr_data = f;
    if (grp_i.done) begin
      wr_data = 2'b00;
      if (f == (SEEN_SET | SEEN_CLEAR)) begin
        kind = KIND_MIXED;
      end else if (f == SEEN_SET) begin
        kind = KIND_BLOCKED;
      end
    end
  end

endmodule

// ===== design/raster_tile_binarize_classify_core.sv =====
// Top level of the raster tile binarize and classify core.
//
//  Channel | Direction | Contents
//  in_     | slave     | tdata[7:0] raw_byte
//  out_    | master    | tdata packed group and position, tlast tile_done, tuser tile_kind
//  cfg_    | APB slave | pixel_mode @0x0, invert_input @0x4, tiles_across @0x8
//
// One item is accepted per cycle while the input is not stalled. A packed group
// passes through the memory stage, where the column's seen flags are read from
// a synchronous memory, then sits in the output register.
// The input stalls only while the memory stage holds a group and the output
// register holds one that is not taken. Reset is synchronous, active low; the
// seen flags read as clear until written.
module raster_tile_binarize_classify_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] raw_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] packed_bits, [13:8] tile_column, [19:14] tile_line,
  // [22:20] group_in_line, [28:23] tile_band, [31:29] zero
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  output logic [1:0]  out_tuser,    // [1:0] tile_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rtbc_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic       in_acc;
  logic       emit;
  grp_t       grp0;
  logic       s1_vld_r;
  grp_t       s1_r;
  logic       s1_adv;
  logic [1:0] kind;
  logic       out_vld_r;
  grp_t       out_r;
  logic [1:0] out_kind_r;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode   <= 1'b0;
      cfg_r.invert_input <= 1'b0;
      cfg_r.tiles_across <= TA_W'(8);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_PIXEL_MODE:   cfg_r.pixel_mode   <= cfg_pwdata[0];
        REG_INVERT_INPUT: cfg_r.invert_input <= cfg_pwdata[0];
        REG_TILES_ACROSS: cfg_r.tiles_across <= cfg_pwdata[TA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_PIXEL_MODE:   cfg_prdata = {31'd0, cfg_r.pixel_mode};
      REG_INVERT_INPUT: cfg_prdata = {31'd0, cfg_r.invert_input};
      REG_TILES_ACROSS: cfg_prdata = {{(32-TA_W){1'b0}}, cfg_r.tiles_across};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // Handshake: the memory stage moves when the output register is empty or its group is taken.
  assign s1_adv    = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  rtbc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .acc      (in_acc),
    .raw_byte (in_tdata),
    .emit     (emit),
    .grp_o    (grp0)
  );

  // Memory stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= emit;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      s1_r <= grp0;
    end
  end

  rtbc_seen u_seen (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc && emit),
    .rd_col (grp0.col),
    .wr_en  (s1_vld_r && s1_adv),
    .grp_i  (s1_r),
    .kind   (kind)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) begin
      out_r      <= s1_r;
      out_kind_r <= kind;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'd0, out_r.band, out_r.grp, out_r.line, out_r.col, out_r.bits};
  assign out_tlast  = out_r.done;
  assign out_tuser  = out_kind_r;

  // A kind is only reported on a tile's last group.
  a_kind_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser == KIND_CLEAR))
    else $error("tile kind set on a group that does not end a tile");

  // The kind code is always a legal one.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_CLEAR || out_tuser == KIND_BLOCKED ||
                    out_tuser == KIND_MIXED))
    else $error("illegal tile kind");

  // Input stalls only when both stages are full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && out_tvalid && !out_tready))
    else $error("input stalled without back-pressure");

  // A tile ends only on the last group of the last line.
  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tdata[19:14] == LINE_W'(TILE_SIZE - 1) &&
       out_tdata[22:20] == GRP_W'(GROUPS_PER_LINE - 1)))
    else $error("tile end flagged at wrong position");

endmodule
